FILE: rtl/tdp_pkg.sv
// ============================================================================
// tdp_pkg
// Control word layout, condition codes and the microprogram of the
// trial-division primality sequencer.
// ============================================================================
package tdp_pkg;

  localparam int STEP_W = 3;

  // datapath operations
  localparam logic [1:0] OP_NOP       = 2'd0;
  localparam logic [1:0] OP_DIV_START = 2'd1;
  localparam logic [1:0] OP_NEXT_D    = 2'd2;
  localparam logic [1:0] OP_REPORT    = 2'd3;

  // jump conditions
  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_START = 3'd2;
  localparam logic [2:0] COND_LT2      = 3'd3;
  localparam logic [2:0] COND_SQ_GT    = 3'd4;
  localparam logic [2:0] COND_DIV_BUSY = 3'd5;
  localparam logic [2:0] COND_REM_NZ   = 3'd6;

  // program steps
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SMALL  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BOUND  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIV    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_COMPOS = 3'd6;
  localparam logic [STEP_W-1:0] STEP_PRIME  = 3'd7;

  typedef struct packed {
    logic              idle;
    logic [1:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              result;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic lt2;
    logic sq_gt;
    logic div_busy;
    logic rem_nz;
  } stat_t;

  // microprogram ROM
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '{idle: 1'b0, op: OP_NOP, cond: COND_NEVER, target: STEP_IDLE, result: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        cw.idle   = 1'b1;
        cw.cond   = COND_NO_START;
        cw.target = STEP_IDLE;
      end
      STEP_SMALL: begin
        cw.cond   = COND_LT2;
        cw.target = STEP_COMPOS;
      end
      STEP_BOUND: begin
        cw.cond   = COND_SQ_GT;
        cw.target = STEP_PRIME;
      end
      STEP_DIV: begin
        cw.op = OP_DIV_START;
      end
      STEP_WAIT: begin
        cw.cond   = COND_DIV_BUSY;
        cw.target = STEP_WAIT;
      end
      STEP_CHECK: begin
        cw.op     = OP_NEXT_D;
        cw.cond   = COND_REM_NZ;
        cw.target = STEP_BOUND;
      end
      STEP_COMPOS: begin
        cw.op     = OP_REPORT;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
        cw.result = 1'b0;
      end
      STEP_PRIME: begin
        cw.op     = OP_REPORT;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
        cw.result = 1'b1;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/trial_division_primality.sv
// ============================================================================
// trial_division_primality
// Primality test of one unsigned word by trial division, run by a
// microcoded sequencer over a divisor / remainder datapath.
// ============================================================================
// Usage:
//   A word is taken at a rising edge with start high and busy low; in_number
//   is sampled there. busy then stays high until the answer is out.
//   The answer appears on out_is_prime for exactly one cycle, flagged by
//   out_valid; the receiver cannot stall and must take it then. The next
//   word can be taken in the cycle the answer is shown.
// Search:
//   Numbers below 2 go from the small-number check straight to a composite
//   report. Otherwise divisors 2, 3, 5, 7, ... are tried while d*d <= number;
//   each trial waits on the remainder unit, which retires two dividend bits a
//   cycle. Worst case (a prime near 2^31 at the default width) is about 23170
//   trials; composites stop at their smallest factor.
// Reset:
//   rst_n low (synchronous) returns the sequencer to idle, drops busy and
//   clears out_valid. No other state carries between words.
// ============================================================================
module trial_division_primality #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  output logic                    out_is_prime
);
  import tdp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  // idle step is the only one that takes a new word
  assign busy   = !ctrl.idle;
  assign accept = start && ctrl.idle;

  tdp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  tdp_dpath #(.W(NUMBER_WIDTH)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .in_number    (in_number),
    .ctrl         (ctrl),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

endmodule

FILE: rtl/tdp_seq.sv
// ============================================================================
// tdp_seq
// Step counter and jump logic; fetches one control word per cycle.
// ============================================================================
module tdp_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  tdp_pkg::stat_t  stat,
  output tdp_pkg::ctrl_t  ctrl
);
  import tdp_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              take;

  assign ctrl = ucode(step_r);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_START: take = !stat.start;
      COND_LT2:      take = stat.lt2;
      COND_SQ_GT:    take = stat.sq_gt;
      COND_DIV_BUSY: take = stat.div_busy;
      COND_REM_NZ:   take = stat.rem_nz;
      default:       take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : step_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: rtl/tdp_rem.sv
// ============================================================================
// tdp_rem
// Iterative remainder unit, two restoring steps (two dividend bits) a cycle.
// ============================================================================
module tdp_rem #(
  parameter int W  = 31,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          rem_zero
);
  localparam int ITER = (W + 1) / 2;
  localparam int NP   = 2 * ITER;
  localparam int CW   = $clog2(ITER + 1);

  logic [NP-1:0] sh_r;
  logic [DW-1:0] r_r, r_nxt;
  logic [CW-1:0] cnt_r;

  always_comb begin
    logic [DW:0] dv, t1, t2;
    dv = {1'b0, divisor};
    t1 = {r_r, sh_r[NP-1]};
    if (t1 >= dv) t1 = t1 - dv;
    t2 = {t1[DW-1:0], sh_r[NP-2]};
    if (t2 >= dv) t2 = t2 - dv;
    r_nxt = t2[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(ITER);
    end else if (busy) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= NP'(dividend);
      r_r  <= '0;
    end else if (busy) begin
      sh_r <= {sh_r[NP-3:0], 2'b00};
      r_r  <= r_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign rem_zero = (r_r == '0);

endmodule

FILE: rtl/tdp_dpath.sv
// ============================================================================
// tdp_dpath
// Number, divisor and divisor-squared registers, bound compare and the
// result register, driven by the sequencer's control word.
// ============================================================================
module tdp_dpath #(
  parameter int W = 31
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic [W-1:0]    in_number,
  input  tdp_pkg::ctrl_t  ctrl,
  output tdp_pkg::stat_t  stat,
  output logic            out_valid,
  output logic            out_is_prime
);
  import tdp_pkg::*;

  localparam int DW = (W + 1) / 2 + 2;
  localparam int SW = W + 2;

  logic [W-1:0]  n_r;
  logic [DW-1:0] d_r;
  logic [SW-1:0] sq_r;
  logic          valid_r, prime_r;
  logic          div_busy, rem_zero;

  // d steps 2, 3, 5, 7, ...; sq tracks d*d
  always_ff @(posedge clk) begin
    if (load) begin
      n_r  <= in_number;
      d_r  <= DW'(2);
      sq_r <= SW'(4);
    end else if (ctrl.op == OP_NEXT_D) begin
      if (d_r == DW'(2)) begin
        d_r  <= DW'(3);
        sq_r <= SW'(9);
      end else begin
        d_r  <= d_r + DW'(2);
        sq_r <= sq_r + (SW'(d_r) << 2) + SW'(4);
      end
    end
  end

  tdp_rem #(.W(W), .DW(DW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.op == OP_DIV_START),
    .dividend (n_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctrl.op == OP_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_REPORT) prime_r <= ctrl.result;
  end

  assign stat.start    = load;
  assign stat.lt2      = (n_r < W'(2));
  assign stat.sq_gt    = (sq_r > SW'(n_r));
  assign stat.div_busy = div_busy;
  assign stat.rem_nz   = !rem_zero;

  assign out_valid    = valid_r;
  assign out_is_prime = prime_r;

endmodule

FILE: tb/sv/trial_division_primality_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// trial_division_primality_chk
// Watches both channels of the primality tester, predicts each answer by
// trial division and compares it with what comes out, in order.
// ============================================================================
module trial_division_primality_chk #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  input  logic                    out_valid,
  input  logic                    out_is_prime,
  output int                      fail_count,
  output int                      answers_due
);

  typedef struct {
    logic [NUMBER_WIDTH-1:0] number;
    logic                    is_prime;
  } answer_t;

  answer_t pending_answers[$];

  // smallest-divisor search, bound kept exact as d <= n / d
  function automatic logic is_prime_by_division(input logic [NUMBER_WIDTH-1:0] n);
    longint unsigned value;
    longint unsigned d;
    value = n;
    if (value < 2) return 1'b0;
    for (d = 2; d <= value / d; d++) begin
      if (value % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t fresh;
    if (!rst_n) begin
      pending_answers.delete();
      fail_count  <= 0;
      answers_due <= 0;
    end else begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          $error("is_prime: no word pending, actual %0b", out_is_prime);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_answers.pop_front();
          if (out_is_prime !== want.is_prime) begin
            $error("is_prime (number %0d): expected %0b, actual %0b",
                   want.number, want.is_prime, out_is_prime);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        fresh.number   = in_number;
        fresh.is_prime = is_prime_by_division(in_number);
        pending_answers.push_back(fresh);
      end
      answers_due <= pending_answers.size();
    end
  end

endmodule

FILE: tb/sv/trial_division_primality_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// trial_division_primality_tb
// Feeds words to the primality tester: a directed set of edge values, then
// random words kept mostly small so the run stays short. The checker beside
// the block predicts and compares; this module gives the verdict.
// ============================================================================
module trial_division_primality_tb;

  localparam int          NUMBER_WIDTH   = 31;
  localparam int unsigned NUMBER_MAX     = 32'((64'd1 << NUMBER_WIDTH) - 64'd1);
  localparam int          RANDOM_WORDS   = 80;
  localparam int          CALM_TAIL      = 20;   // last words sent with no idling
  localparam int          DRAIN_CYCLES   = 20;   // wait after the checker has no answer due
  // must outlast the search for a prime near the top of the range
  localparam int          WATCHDOG_LIMIT = 2_000_000;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic [NUMBER_WIDTH-1:0] in_number = '0;
  logic                    busy;
  logic                    out_valid;
  logic                    out_is_prime;
  int                      fail_count;
  int                      answers_due;
  int                      quiet_cycles = 0;
  bit                      idling_on    = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  trial_division_primality #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  trial_division_primality_chk #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  // watchdog: any accepted word on either side clears the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold start high until the block takes the word. start is only lowered
  // for an idle burst, so back-to-back words never toggle it within a step.
  task automatic send_word(input logic [NUMBER_WIDTH-1:0] n);
    start     <= 1'b1;
    in_number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idling_on && $urandom_range(99) < 30) begin
      start     <= 1'b0;
      in_number <= NUMBER_WIDTH'($urandom);   // ignored while start is low
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
  endtask

  // Mostly small words; wide words carry a small factor so they end fast
  // and a random wide prime never stalls the run with a long search.
  function automatic logic [NUMBER_WIDTH-1:0] pick_number();
    int unsigned kind;
    int unsigned factor;
    kind = $urandom_range(99);
    if (kind < 45) return NUMBER_WIDTH'($urandom_range(1023));
    if (kind < 70) return NUMBER_WIDTH'($urandom_range(65535));
    if (kind < 85) return NUMBER_WIDTH'($urandom_range(262143));
    factor = $urandom_range(97, 2);
    return NUMBER_WIDTH'(factor * $urandom_range(NUMBER_MAX / factor, 1));
  endfunction

  initial begin
    int unsigned edge_words[$];
    edge_words = '{
      0, 1,                     // below two: never prime
      2, 3,                     // no divisor under the bound
      4, 5, 97,
      9, 25, 49, 121, 1042441,  // prime squares: divisor equals the bound
      65521, 65537,
      32'h4000_0000,            // single high bit
      32'h5555_5555, 32'h2AAA_AAAA,
      NUMBER_MAX - 1,
      NUMBER_MAX                // all ones, prime: longest search
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (edge_words[i]) send_word(NUMBER_WIDTH'(edge_words[i]));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i >= RANDOM_WORDS - CALM_TAIL) idling_on = 1'b0;
      send_word(pick_number());
    end
    start <= 1'b0;

    // answers_due is registered, so step the clock before looking at it
    do @(posedge clk); while (answers_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && answers_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: trial_division_primality.f
rtl/tdp_pkg.sv
rtl/tdp_seq.sv
rtl/tdp_rem.sv
rtl/tdp_dpath.sv
rtl/trial_division_primality.sv
tb/sv/trial_division_primality_chk.sv
tb/sv/trial_division_primality_tb.sv
